/* rtl/stereo_rms_level_meter_top_assert.svh */
// ----------------------------------------------------------------------------
// stereo_rms_level_meter_top_assert
// Assertion macros for the stereo RMS level meter.
// Each macro expects a clock named clk and a reset named rst in scope.
// ----------------------------------------------------------------------------
`ifndef STEREO_RMS_LEVEL_METER_TOP_ASSERT_SVH
`define STEREO_RMS_LEVEL_METER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RLM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("level meter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RLM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("level meter assertion failed");

`endif

/* rtl/rlm_pkg.sv */
// ----------------------------------------------------------------------------
// rlm_pkg
// Types and constants shared by the stereo RMS level meter modules.
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int SQ_W           = 29;   // square of a halved sample, at most 2^28
  localparam int SUM_W          = 38;
  localparam int ACC_W          = 31;
  localparam int LEVEL_W        = 15;
  localparam int FRAME_W        = 32;
  localparam int MAX_FRAMES_DEF = 256;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX   = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd16384;
  localparam logic [15:0]        COEF_KEEP = 16'd60948;
  localparam logic [12:0]        COEF_NEW  = 13'd4588;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       last_in_frame;
  } pair_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_level;
    logic [LEVEL_W-1:0] smoothed_level;
    logic [FRAME_W-1:0] frame_count;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/rlm_queue.sv */
// ----------------------------------------------------------------------------
// rlm_queue
// Short FIFO that carries closed frames from the front to the back.
// ----------------------------------------------------------------------------
module rlm_queue
  import rlm_pkg::*;
#(
  parameter int W = 51
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output q_stat_t      stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/rlm_front.sv */
// ----------------------------------------------------------------------------
// rlm_front
// Squares halved sample pairs, accumulates the frame sum and pair count,
// and hands each closed frame to the queue.
// ----------------------------------------------------------------------------
module rlm_front
  import rlm_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int CNT_W      = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pair_t                  pair,
  output logic                   full,
  input  q_stat_t                q_stat,
  output logic                   q_push,
  output logic [SUM_W+CNT_W-1:0] q_data
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAMES);

  logic signed [SAMPLE_W-2:0] half_l;
  logic signed [SAMPLE_W-2:0] half_r;
  logic signed [29:0]         sq_l;
  logic signed [29:0]         sq_r;

  logic            s1_valid;
  logic            s1_last;
  logic [SQ_W-1:0] s1_sql;
  logic [SQ_W-1:0] s1_sqr;

  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic [CNT_W-1:0] cnt_inc;
  logic             stall;
  logic             advance;

  // Dropping the low bit of a signed sample is the arithmetic halving.
  assign half_l = $signed(pair.left_sample[SAMPLE_W-1:1]);
  assign half_r = $signed(pair.right_sample[SAMPLE_W-1:1]);
  assign sq_l   = half_l * half_l;
  assign sq_r   = half_r * half_r;

  assign stall   = s1_valid && s1_last && q_stat.full;
  assign advance = s1_valid && !stall;
  assign full    = stall;

  assign sum_wide = {1'b0, sum} + (SUM_W+1)'(s1_sql) + (SUM_W+1)'(s1_sqr);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign cnt_inc  = (cnt < CNT_MAX) ? cnt + 1'b1 : cnt;

  assign q_push = advance && s1_last;
  assign q_data = {sum_sat, cnt_inc};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      sum      <= '0;
      cnt      <= '0;
    end else begin
      if (advance) begin
        if (s1_last) begin
          sum <= '0;
          cnt <= '0;
        end else begin
          sum <= sum_sat;
          cnt <= cnt_inc;
        end
      end
      if (!stall) begin
        s1_valid <= push;
        s1_last  <= pair.last_in_frame;
        s1_sql   <= sq_l[SQ_W-1:0];
        s1_sqr   <= sq_r[SQ_W-1:0];
      end
    end
  end

endmodule

/* rtl/rlm_back.sv */
// ----------------------------------------------------------------------------
// rlm_back
// Per-frame sequencer: divides the sum by twice the pair count, takes the
// integer square root, updates the smoother and loads the result register.
// ----------------------------------------------------------------------------
module rlm_back
  import rlm_pkg::*;
#(
  parameter int CNT_W = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  q_stat_t                q_stat,
  input  logic [SUM_W+CNT_W-1:0] q_data,
  output logic                   q_pop,
  input  logic                   pop,
  output logic                   empty,
  output result_t                result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQRT,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  state_t state;

  logic [SUM_W-1:0] dvd;
  logic [CNT_W:0]   dsr;
  logic [CNT_W:0]   rem;
  logic [5:0]       step;
  logic [CNT_W+1:0] trial_div;
  logic             div_ge;
  logic [CNT_W+1:0] div_diff;
  logic [CNT_W:0]   rem_next;
  logic [SUM_W-1:0] dvd_next;

  logic [SUM_W-1:0] x;
  logic [SUM_W-1:0] res;
  logic [SUM_W-1:0] rbit;
  logic [SUM_W-1:0] trial_root;

  logic [LEVEL_W-1:0] rms;
  logic [LEVEL_W-1:0] rms_c;
  logic [46:0]        prod_keep;
  logic [27:0]        prod_new;
  logic [31:0]        acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [ACC_W-1:0]   acc;
  logic [LEVEL_W-1:0] lvl;
  logic [FRAME_W-1:0] frames;
  logic               out_valid;

  // One restoring division step: shift in the next dividend bit.
  assign trial_div = {rem, dvd[SUM_W-1]};
  assign div_ge    = (trial_div >= {1'b0, dsr});
  assign div_diff  = trial_div - {1'b0, dsr};
  assign rem_next  = div_ge ? div_diff[CNT_W:0] : trial_div[CNT_W:0];
  assign dvd_next  = {dvd[SUM_W-2:0], div_ge};

  assign trial_root = res + rbit;
  assign rms_c      = (res > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : res[LEVEL_W-1:0];

  assign acc_sum = 32'(prod_keep[46:16]) + 32'(prod_new);
  assign acc_sat = acc_sum[31] ? ACC_MAX : acc_sum[ACC_W-1:0];
  assign lvl     = (acc[ACC_W-1:16] > LEVEL_MAX) ? LEVEL_MAX : acc[ACC_W-1:16];

  assign q_pop = (state == S_IDLE) && !q_stat.empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      frames    <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new result may replace the one taken in the same beat.
      if ((state == S_DONE) && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            dvd   <= q_data[CNT_W +: SUM_W];
            dsr   <= {q_data[CNT_W-1:0], 1'b0};
            rem   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dvd  <= dvd_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (step == 6'(SUM_W - 1)) begin
            x     <= dvd_next;
            res   <= '0;
            rbit  <= SUM_W'(1) << (SUM_W - 2);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (rbit != '0) begin
            if (x >= trial_root) begin
              x   <= x - trial_root;
              res <= (res >> 1) + rbit;
            end else begin
              res <= res >> 1;
            end
            rbit <= rbit >> 2;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          rms       <= rms_c;
          prod_keep <= 47'(acc) * 47'(COEF_KEEP);
          prod_new  <= 28'(rms_c) * 28'(COEF_NEW);
          state     <= S_ADD;
        end
        S_ADD: begin
          acc    <= acc_sat;
          frames <= frames + 1'b1;
          state  <= S_DONE;
        end
        S_DONE: begin
          // Wait here while the previous result has not been taken.
          if (!out_valid || pop) begin
            result.rms_level      <= rms;
            result.smoothed_level <= lvl;
            result.frame_count    <= frames;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/stereo_rms_level_meter_top.sv */
// ----------------------------------------------------------------------------
// stereo_rms_level_meter_top
// Stereo RMS level meter with a one-pole smoothed level output.
// ----------------------------------------------------------------------------
// The front accepts one stereo pair per clock through push/full, while full
// is low, and keeps the frame's sum of squares and pair count; each pair's
// squares are registered before they are added to the sum. Each pair marked
// last in frame closes the frame into a two-entry queue, and full rises only
// while that queue is full and a closing pair waits. The back works one frame
// at a time: a bit-serial 38-step divider, a 19-step square root, multiply,
// add and result load. Results wait in an output register read through
// empty/pop; the back works on but waits to load until the last is popped.
// ----------------------------------------------------------------------------
module stereo_rms_level_meter_top
  import rlm_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  pair_t   pair,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  q_stat_t                q_stat;
  logic                   q_push;
  logic                   q_pop;
  logic [SUM_W+CNT_W-1:0] q_wdata;
  logic [SUM_W+CNT_W-1:0] q_rdata;

  rlm_front #(
    .MAX_FRAMES(MAX_FRAMES),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pair  (pair),
    .full  (full),
    .q_stat(q_stat),
    .q_push(q_push),
    .q_data(q_wdata)
  );

  rlm_queue #(
    .W(SUM_W + CNT_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  rlm_back #(
    .CNT_W(CNT_W)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .q_stat(q_stat),
    .q_data(q_rdata),
    .q_pop (q_pop),
    .pop   (pop),
    .empty (empty),
    .result(result)
  );

`include "stereo_rms_level_meter_top_assert.svh"

  // The front never writes a closed frame into a full queue.
  `RLM_ASSERT_IMP(a_queue_no_overflow, q_push, !q_stat.full)
  // The back only takes a frame that is there.
  `RLM_ASSERT_IMP(a_queue_no_underflow, q_pop, !q_stat.empty)
  // Back pressure on the input comes only from a full queue.
  `RLM_ASSERT_IMP(a_full_from_queue, full, q_stat.full)
  // Both levels stay clamped to full scale.
  `RLM_ASSERT_IMP(a_level_clamp, !empty,
    (result.rms_level <= LEVEL_MAX) && (result.smoothed_level <= LEVEL_MAX))

endmodule

/* tb/sv/level_meter_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// level_meter_checker
// Watches the pair and result queues of the stereo level meter, predicts the
// result of every closed frame and compares it with what the block returns.
// ----------------------------------------------------------------------------
module level_meter_checker
  import rlm_pkg::*;
#(
  parameter int MAX_PAIRS = MAX_FRAMES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  pair_t   pair,
  input  logic    empty,
  input  logic    pop,
  input  result_t result,
  output int      mismatches,
  output int      pending
);

  localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

  longint unsigned    frame_sum;
  int unsigned        frame_pairs;
  longint unsigned    level_acc;
  logic [FRAME_W-1:0] frames_closed;
  result_t            frame_results[$];

  function automatic longint unsigned halved_square(logic signed [SAMPLE_W-1:0] s);
    logic signed [SAMPLE_W-1:0] h;
    longint v;
    h = s >>> 1;
    v = h;
    return v * v;
  endfunction

  // Floor square root, one result bit per step from the top.
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int i = 20; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  task automatic absorb_pair(input pair_t p);
    longint unsigned mean;
    longint unsigned rms;
    longint unsigned lvl;
    result_t r;
    frame_sum = frame_sum + halved_square(p.left_sample) + halved_square(p.right_sample);
    if (frame_sum > SUM_LIMIT) frame_sum = SUM_LIMIT;
    if (frame_pairs < MAX_PAIRS) frame_pairs++;
    if (p.last_in_frame) begin
      mean = frame_sum / (64'd2 * frame_pairs);
      rms = floor_root(mean);
      if (rms > LEVEL_MAX) rms = LEVEL_MAX;
      level_acc = ((level_acc * COEF_KEEP) >> 16) + rms * COEF_NEW;
      if (level_acc > ACC_MAX) level_acc = ACC_MAX;
      frames_closed = frames_closed + 1'b1;
      lvl = level_acc >> 16;
      if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
      r.rms_level      = LEVEL_W'(rms);
      r.smoothed_level = LEVEL_W'(lvl);
      r.frame_count    = frames_closed;
      frame_results.insert(frame_results.size(), r);
      frame_sum   = 0;
      frame_pairs = 0;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (frame_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result beat with no frame closed: rms=%0d smoothed=%0d count=%0d",
                 $time, got.rms_level, got.smoothed_level, got.frame_count);
    end else begin
      want = frame_results.pop_front();
      if (got.rms_level !== want.rms_level || got.smoothed_level !== want.smoothed_level ||
          got.frame_count !== want.frame_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected rms=%0d lvl=%0d n=%0d, got rms=%0d lvl=%0d n=%0d",
                   $time, want.rms_level, want.smoothed_level, want.frame_count,
                   got.rms_level, got.smoothed_level, got.frame_count);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatches    = 0;
      frame_sum     = 0;
      frame_pairs   = 0;
      level_acc     = 0;
      frames_closed = '0;
      frame_results.delete();
    end else begin
      if (pop && !empty) check_result(result);
      if (push && !full) absorb_pair(pair);
    end
    pending = frame_results.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives stereo sample pairs into the level meter under varying back
// pressure and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  import rlm_pkg::*;

  typedef enum int {
    ANY_VALUE,
    EDGE_VALUE,
    QUIET_VALUE,
    LOUD_VALUE,
    FULL_SCALE,
    MIXED_VALUE
  } sample_style_t;

  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_PAIRS  = 20;
  localparam int SETTLE_CYCLES = 200;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  pair_t   pair = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int pairs_sent    = 0;

  always #6 clk = ~clk;

  stereo_rms_level_meter_top #(
    .MAX_FRAMES(MAX_FRAMES_DEF)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .pair   (pair),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  level_meter_checker #(
    .MAX_PAIRS(MAX_FRAMES_DEF)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pair       (pair),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      pop <= 1'b0;
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #(12 * 1000000);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample(sample_style_t style);
    sample_style_t s;
    int v;
    s = style;
    if (s == MIXED_VALUE) s = sample_style_t'($urandom_range(3));
    case (s)
      EDGE_VALUE: begin
        case ($urandom_range(5))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          3: v = 1;
          4: v = 0;
          default: v = -2;
        endcase
      end
      QUIET_VALUE: v = int'($urandom_range(600)) - 300;
      LOUD_VALUE: begin
        v = int'($urandom_range(32767, 30000));
        if ($urandom_range(1)) v = -v - 1;
      end
      FULL_SCALE: v = $urandom_range(1) ? 32767 : -32768;
      default: v = $urandom;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // Called right after a falling edge; returns right after the falling edge
  // that follows the accepting beat, with push still high.
  task automatic send_pair(input int l, input int r, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    pair <= '{left_sample: l[SAMPLE_W-1:0], right_sample: r[SAMPLE_W-1:0],
              last_in_frame: last};
    @(posedge clk);
    while (full) @(posedge clk);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input sample_style_t style);
    for (int i = 1; i <= len; i++)
      send_pair(int'(signed'(pick_sample(style))), int'(signed'(pick_sample(style))),
                i == len);
  endtask

  task automatic random_frame();
    int len;
    sample_style_t style;
    len = $urandom_range(6, 1);
    style = ($urandom_range(3) == 0) ? QUIET_VALUE : MIXED_VALUE;
    send_frame(len, style);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int start;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames: full-scale extremes, rounding of the halving shift,
    // silence, and a few multi-pair frames.
    send_pair(32767, 32767, 1'b1);
    send_pair(-32768, -32768, 1'b1);
    send_pair(0, 0, 1'b1);
    send_pair(-1, -1, 1'b1);
    send_pair(1, 1, 1'b1);
    send_pair(32767, -32768, 1'b0);
    send_pair(-32768, 32767, 1'b1);
    send_pair(-3, 3, 1'b0);
    send_pair(2, -2, 1'b0);
    send_pair(100, -100, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    send_pair(-2, 1, 1'b1);
    wait_drained();

    // Full-scale frame long enough to saturate the sum and the pair count.
    send_frame(530, FULL_SCALE);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Hold the result side off while single-pair frames keep arriving,
          // so the frame queue fills and full stalls the input.
          hold_requests++;
          for (int i = 0; i < 12; i++) send_frame(1, MIXED_VALUE);
          wait_drained();
        end
      endcase
      start = pairs_sent;
      while (pairs_sent - start < PHASE_PAIRS) random_frame();
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/rlm_pkg.sv
rtl/rlm_queue.sv
rtl/rlm_front.sv
rtl/rlm_back.sv
rtl/stereo_rms_level_meter_top.sv
tb/sv/level_meter_checker.sv
tb/sv/testbench.sv
